// ===== src/lpfr_pkg.sv =====
// Shared types and constants for the light pulse/fade intensity ramp.
// No dependencies; used by the controller, datapath, top level and checker.
package lpfr_pkg;

    // Q2.15 intensity factor, 0 .. 1.0 inclusive, 17 bits
    localparam int FRAC_BITS = 15;
    localparam int FACTOR_W  = FRAC_BITS + 2;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << FRAC_BITS;

    // one quotient bit per divider step
    localparam int DIV_CNT_W = $clog2(FRAC_BITS);

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_EFFECT_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EFFECT_TIME = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_NOW   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_RED    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_GREEN  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_BLUE   = 3'd5;

    // effect modes; the unused code behaves as no effect
    localparam logic [1:0] EFFECT_NONE  = 2'd0;
    localparam logic [1:0] EFFECT_PULSE = 2'd1;
    localparam logic [1:0] EFFECT_FADE  = 2'd2;

    // request kinds on the input channel
    localparam logic [1:0] ITEM_TICK      = 2'd0;
    localparam logic [1:0] ITEM_TRIGGER   = 2'd1;
    localparam logic [1:0] ITEM_LIGHT_ON  = 2'd2;
    localparam logic [1:0] ITEM_LIGHT_OFF = 2'd3;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } colour_ch_t;

    typedef struct packed {
        logic       accept;
        logic       div_step;
        logic       update;
        logic       mul_en;
        colour_ch_t mul_ch;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tick_run;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/light_pulse_fade_ramp.sv =====
// Light intensity effect generator (pulse triangle / linear fade) driving a scaled colour.
// Top level; instantiates lpfr_ctrl and lpfr_dp, depends on lpfr_pkg.
//
// Usage:
//   Input requests (s_valid/s_ready) carry s_mode and s_elapsed_time. Trigger, light-on
//   and light-off requests give no result. A tick request while the effect runs advances
//   the Q2.15 intensity factor and gives one result (m_valid/m_ready): the base colour
//   scaled by the factor, or black with the light off. A tick while the effect waits for
//   a trigger gives nothing. A running tick passes from acceptance to m_valid through the
//   serial step divider (one quotient bit a cycle), one factor update, the shared colour
//   multiplier (red, then green, then blue) and one output load. s_ready is low over that
//   span, so the block takes no new request until the running tick is through.
//   The result sits in an output register; the next request is accepted while it waits.
//   If the receiver still stalls when the following result is ready, the block holds
//   it and keeps s_ready low until the output register frees.
//   Reset (aresetn low, synchronous) sets the factor to 1.0, falling, untriggered, light
//   on, and the configuration registers to their defaults. Configuration is written
//   through cfg_we/cfg_index/cfg_data while no request is in progress.
module light_pulse_fade_ramp #(
    parameter int TIME_BITS  = 16,
    parameter int COLOR_BITS = 8,
    parameter int CFG_W      = (TIME_BITS > COLOR_BITS) ? TIME_BITS : COLOR_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [lpfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]                   cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_mode,
    input  logic [TIME_BITS-1:0]               s_elapsed_time,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [COLOR_BITS-1:0]              m_red_out,
    output logic [COLOR_BITS-1:0]              m_green_out,
    output logic [COLOR_BITS-1:0]              m_blue_out
);

    lpfr_pkg::ctrl_cmd_t  cmd;
    lpfr_pkg::dp_status_t status;

    lpfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lpfr_dp #(
        .TIME_BITS  (TIME_BITS),
        .COLOR_BITS (COLOR_BITS),
        .CFG_W      (CFG_W)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_mode         (s_mode),
        .s_elapsed_time (s_elapsed_time),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_red_out      (m_red_out),
        .m_green_out    (m_green_out),
        .m_blue_out     (m_blue_out),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

// ===== src/lpfr_ctrl.sv =====
// Sequencer for the intensity ramp: divide, update factor, scale colours, load output.
// Depends on lpfr_pkg.
module lpfr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lpfr_pkg::dp_status_t  status,
    output lpfr_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPDATE,
        ST_MUL_R,
        ST_MUL_G,
        ST_MUL_B,
        ST_LOAD
    } state_t;

    state_t                          state_reg, state_next;
    logic [lpfr_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.mul_ch   = lpfr_pkg::CH_RED;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && status.tick_run) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == lpfr_pkg::DIV_CNT_W'(lpfr_pkg::FRAC_BITS - 1)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_MUL_R;
            end
            ST_MUL_R: begin
                cmd.mul_en = 1'b1;
                cmd.mul_ch = lpfr_pkg::CH_RED;
                state_next = ST_MUL_G;
            end
            ST_MUL_G: begin
                cmd.mul_en = 1'b1;
                cmd.mul_ch = lpfr_pkg::CH_GREEN;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.mul_en = 1'b1;
                cmd.mul_ch = lpfr_pkg::CH_BLUE;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // wait here until the output register is free
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lpfr_dp.sv =====
// Datapath: config registers, effect state, serial step divider, colour scaler, output register.
// Depends on lpfr_pkg; sequenced by lpfr_ctrl.
module lpfr_dp #(
    parameter int TIME_BITS  = 16,
    parameter int COLOR_BITS = 8,
    parameter int CFG_W      = (TIME_BITS > COLOR_BITS) ? TIME_BITS : COLOR_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [lpfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]                   cfg_data,
    input  logic [1:0]                         s_mode,
    input  logic [TIME_BITS-1:0]               s_elapsed_time,
    input  logic                               m_ready,
    output logic                               m_valid,
    output logic [COLOR_BITS-1:0]              m_red_out,
    output logic [COLOR_BITS-1:0]              m_green_out,
    output logic [COLOR_BITS-1:0]              m_blue_out,
    input  lpfr_pkg::ctrl_cmd_t                cmd,
    output lpfr_pkg::dp_status_t               status
);

    localparam int FW     = lpfr_pkg::FACTOR_W;
    localparam int QW     = lpfr_pkg::FRAC_BITS;
    localparam int PROD_W = COLOR_BITS + FW;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (lpfr_pkg::FRAC_BITS - 1);

    // configuration
    logic [1:0]            effect_mode_reg;
    logic [TIME_BITS-1:0]  effect_time_reg;
    logic                  start_now_reg;
    logic [COLOR_BITS-1:0] base_red_reg, base_green_reg, base_blue_reg;

    // effect state
    logic [FW-1:0]         factor_reg, factor_next;
    logic                  rising_reg, rising_next;
    logic                  triggered_reg;
    logic                  light_on_reg;

    // divider
    logic [TIME_BITS-1:0]  rem_reg;
    logic [QW-1:0]         quot_reg;
    logic                  sat_reg;
    logic [TIME_BITS-1:0]  t_eff;
    logic [TIME_BITS:0]    rem_dbl;
    logic                  rem_ge;

    // scaler and output
    logic [COLOR_BITS-1:0] res_red_reg, res_green_reg, res_blue_reg;
    logic [COLOR_BITS-1:0] base_sel, scaled;
    logic [PROD_W-1:0]     prod, rounded;
    logic                  m_valid_reg;

    logic [FW-1:0]         step;
    logic [FW:0]           sum;
    logic [FW-1:0]         diff;
    logic                  under;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            effect_mode_reg <= lpfr_pkg::EFFECT_NONE;
            effect_time_reg <= TIME_BITS'(1000);
            start_now_reg   <= 1'b1;
            base_red_reg    <= '1;
            base_green_reg  <= '1;
            base_blue_reg   <= '1;
        end else if (cfg_we) begin
            case (cfg_index)
                lpfr_pkg::CFG_EFFECT_MODE: effect_mode_reg <= cfg_data[1:0];
                lpfr_pkg::CFG_EFFECT_TIME: effect_time_reg <= cfg_data[TIME_BITS-1:0];
                lpfr_pkg::CFG_START_NOW:   start_now_reg   <= cfg_data[0];
                lpfr_pkg::CFG_BASE_RED:    base_red_reg    <= cfg_data[COLOR_BITS-1:0];
                lpfr_pkg::CFG_BASE_GREEN:  base_green_reg  <= cfg_data[COLOR_BITS-1:0];
                lpfr_pkg::CFG_BASE_BLUE:   base_blue_reg   <= cfg_data[COLOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign status.tick_run = (s_mode == lpfr_pkg::ITEM_TICK) && (start_now_reg || triggered_reg);
    assign status.out_free = !m_valid_reg || m_ready;

    // zero effect time acts as 1 ms
    assign t_eff   = (effect_time_reg == '0) ? TIME_BITS'(1) : effect_time_reg;
    // remainder stays below t_eff, so doubling fits one extra bit
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_ge  = rem_dbl >= {1'b0, t_eff};

    // elapsed >= time means the step is at least 1.0: saturate, skip the quotient
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rem_reg  <= s_elapsed_time;
            sat_reg  <= s_elapsed_time >= t_eff;
            quot_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= rem_ge ? TIME_BITS'(rem_dbl - {1'b0, t_eff}) : rem_dbl[TIME_BITS-1:0];
            quot_reg <= {quot_reg[QW-2:0], rem_ge};
        end
    end

    assign step  = sat_reg ? lpfr_pkg::FACTOR_ONE : FW'(quot_reg);
    assign sum   = {1'b0, factor_reg} + {1'b0, step};
    assign under = step > factor_reg;
    assign diff  = factor_reg - step;

    always_comb begin
        factor_next = factor_reg;
        rising_next = rising_reg;
        case (effect_mode_reg)
            lpfr_pkg::EFFECT_PULSE: begin
                if (rising_reg) begin
                    if (sum > {1'b0, lpfr_pkg::FACTOR_ONE}) begin
                        factor_next = lpfr_pkg::FACTOR_ONE;
                        rising_next = 1'b0;
                    end else begin
                        factor_next = sum[FW-1:0];
                    end
                end else begin
                    if (under) begin
                        factor_next = '0;
                        rising_next = 1'b1;
                    end else begin
                        factor_next = diff;
                    end
                end
            end
            lpfr_pkg::EFFECT_FADE: begin
                if (factor_reg != '0) begin
                    factor_next = under ? '0 : diff;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg    <= lpfr_pkg::FACTOR_ONE;
            rising_reg    <= 1'b0;
            triggered_reg <= 1'b0;
            light_on_reg  <= 1'b1;
        end else begin
            if (cmd.update) begin
                factor_reg <= factor_next;
                rising_reg <= rising_next;
            end
            if (cmd.accept) begin
                case (s_mode)
                    lpfr_pkg::ITEM_TRIGGER: begin
                        if (!start_now_reg) begin
                            triggered_reg <= 1'b1;
                        end
                    end
                    lpfr_pkg::ITEM_LIGHT_ON:  light_on_reg <= 1'b1;
                    lpfr_pkg::ITEM_LIGHT_OFF: light_on_reg <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // one shared multiplier, one colour per cycle
    always_comb begin
        case (cmd.mul_ch)
            lpfr_pkg::CH_GREEN: base_sel = base_green_reg;
            lpfr_pkg::CH_BLUE:  base_sel = base_blue_reg;
            default:            base_sel = base_red_reg;
        endcase
    end

    assign prod    = PROD_W'(base_sel) * PROD_W'(factor_reg);
    assign rounded = prod + ROUND_HALF;
    assign scaled  = light_on_reg ? rounded[lpfr_pkg::FRAC_BITS +: COLOR_BITS] : '0;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            case (cmd.mul_ch)
                lpfr_pkg::CH_GREEN: res_green_reg <= scaled;
                lpfr_pkg::CH_BLUE:  res_blue_reg  <= scaled;
                default:            res_red_reg   <= scaled;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_red_out   <= res_red_reg;
            m_green_out <= res_green_reg;
            m_blue_out  <= res_blue_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== src/lpfr_checker.sv =====
// Port-level checks for light_pulse_fade_ramp, attached by bind.
// Depends on lpfr_pkg and the top-level port list.
module lpfr_checker #(
    parameter int TIME_BITS  = 16,
    parameter int COLOR_BITS = 8
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [1:0]            s_mode,
    input logic [TIME_BITS-1:0]  s_elapsed_time,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [COLOR_BITS-1:0] m_red_out,
    input logic [COLOR_BITS-1:0] m_green_out,
    input logic [COLOR_BITS-1:0] m_blue_out
);

    // stalled request from upstream holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_mode) && $stable(s_elapsed_time))
        else $error("input request changed while stalled");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_out)
            && $stable(m_green_out) && $stable(m_blue_out))
        else $error("result changed while stalled");

    // a result only appears out of a busy tick
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a tick in progress");

    // non-tick requests do not hold the input channel
    a_ctrl_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode != lpfr_pkg::ITEM_TICK) |=> s_ready)
        else $error("control request held the input channel");

    // nothing pending straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind light_pulse_fade_ramp lpfr_checker #(
    .TIME_BITS  (TIME_BITS),
    .COLOR_BITS (COLOR_BITS)
) u_lpfr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_mode         (s_mode),
    .s_elapsed_time (s_elapsed_time),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_red_out      (m_red_out),
    .m_green_out    (m_green_out),
    .m_blue_out     (m_blue_out)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for light_pulse_fade_ramp: random valid/ready traffic with an
// in-bench intensity ramp predictor. Depends on lpfr_pkg and the light_pulse_fade_ramp top.
module tb;

    localparam int STUCK_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE_CYC  = 40;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] elapsed;
    } lamp_req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [lpfr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = lpfr_pkg::ITEM_TICK;
    logic [15:0] s_elapsed_time = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_red_out, m_green_out, m_blue_out;

    light_pulse_fade_ramp i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_elapsed_time (s_elapsed_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red_out      (m_red_out),
        .m_green_out    (m_green_out),
        .m_blue_out     (m_blue_out)
    );

    always #5 aclk = ~aclk;

    // shadow of the block's registers and effect state
    logic [1:0]  fx_mode = lpfr_pkg::EFFECT_NONE;
    logic [15:0] fx_time = 16'd1000;
    logic        fx_start_now = 1'b1;
    logic [7:0]  base_r = 8'd255, base_g = 8'd255, base_b = 8'd255;
    int          intensity = 32768;
    logic        rising = 1'b0;
    logic        triggered = 1'b0;
    logic        light_on = 1'b1;

    lamp_req_t pending_reqs[$];
    colour_t   expected_colours[$];

    int  n_errors = 0;
    int  n_accepted = 0;
    int  n_checked = 0;
    int  n_turns = 0;
    int  n_phases = 0;
    int  s_idle_pct = 0;
    int  m_idle_pct = 0;
    int  s_gap = 0;
    int  m_gap = 0;
    int  hold_left = 0;
    int  stuck_cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    logic s_taken = 1'b0;

    function automatic int ramp_step(logic [15:0] el);
        longint unsigned t;
        longint unsigned q;
        t = (fx_time == 16'd0) ? 1 : longint'(fx_time);
        q = (longint'(el) << 15) / t;
        return (q > 32768) ? 32768 : int'(q);
    endfunction

    function automatic logic [7:0] scale_colour(logic [7:0] base);
        longint unsigned v;
        v = (longint'(base) * longint'(intensity) + 16384) >> 15;
        return v[7:0];
    endfunction

    task automatic apply_request(lamp_req_t rq);
        int f;
        colour_t c;
        case (rq.mode)
            lpfr_pkg::ITEM_TRIGGER:   if (!fx_start_now) triggered = 1'b1;
            lpfr_pkg::ITEM_LIGHT_ON:  light_on = 1'b1;
            lpfr_pkg::ITEM_LIGHT_OFF: light_on = 1'b0;
            default: begin
                if (fx_start_now || triggered) begin
                    f = intensity;
                    if (fx_mode == lpfr_pkg::EFFECT_PULSE) begin
                        if (rising) begin
                            f += ramp_step(rq.elapsed);
                            if (f > 32768) begin
                                f = 32768;
                                rising = 1'b0;
                                n_turns++;
                            end
                        end else begin
                            f -= ramp_step(rq.elapsed);
                            if (f < 0) begin
                                f = 0;
                                rising = 1'b1;
                                n_turns++;
                            end
                        end
                    end else if (fx_mode == lpfr_pkg::EFFECT_FADE && f > 0) begin
                        f -= ramp_step(rq.elapsed);
                        if (f < 0) f = 0;
                    end
                    intensity = f;
                    if (light_on) begin
                        c.red   = scale_colour(base_r);
                        c.green = scale_colour(base_g);
                        c.blue  = scale_colour(base_b);
                    end else begin
                        c = '0;
                    end
                    expected_colours.push_back(c);
                end
            end
        endcase
    endtask

    task automatic check_chan(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // request acceptance feeds the predictor
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            apply_request('{mode: s_mode, elapsed: s_elapsed_time});
            n_accepted++;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        colour_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_colours.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                         $time, m_red_out, m_green_out, m_blue_out);
                n_errors++;
            end else begin
                want = expected_colours.pop_front();
                check_chan("red", want.red, m_red_out);
                check_chan("green", want.green, m_green_out);
                check_chan("blue", want.blue, m_blue_out);
                n_checked++;
            end
        end
    end

    // sender: one request at a time from the pending queue
    always @(negedge aclk) begin
        lamp_req_t rq;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (s_gap > 0) begin
                s_gap--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !quiet
                         && $urandom_range(0, 99) < s_idle_pct) begin
                s_gap = $urandom_range(0, 3);
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                rq = pending_reqs.pop_front();
                s_valid <= 1'b1;
                s_mode <= rq.mode;
                s_elapsed_time <= rq.elapsed;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: short random stalls, one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < m_idle_pct) begin
            m_gap = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, stuck_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [lpfr_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            lpfr_pkg::CFG_EFFECT_MODE: fx_mode = val[1:0];
            lpfr_pkg::CFG_EFFECT_TIME: fx_time = val;
            lpfr_pkg::CFG_START_NOW:   fx_start_now = val[0];
            lpfr_pkg::CFG_BASE_RED:    base_r = val[7:0];
            lpfr_pkg::CFG_BASE_GREEN:  base_g = val[7:0];
            lpfr_pkg::CFG_BASE_BLUE:   base_b = val[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [1:0] fx, logic [15:0] t, logic now,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
        write_reg(lpfr_pkg::CFG_EFFECT_MODE, 16'(fx));
        write_reg(lpfr_pkg::CFG_EFFECT_TIME, t);
        write_reg(lpfr_pkg::CFG_START_NOW, 16'(now));
        write_reg(lpfr_pkg::CFG_BASE_RED, 16'(r));
        write_reg(lpfr_pkg::CFG_BASE_GREEN, 16'(g));
        write_reg(lpfr_pkg::CFG_BASE_BLUE, 16'(b));
        n_phases++;
    endtask

    task automatic push_req(logic [1:0] mode, logic [15:0] el);
        pending_reqs.push_back('{mode: mode, elapsed: el});
    endtask

    // wait for every request to go in and every result to come out, then let
    // a request that gives no result finish inside the block
    task automatic settle();
        do @(posedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_colours.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_elapsed();
        int unsigned span;
        span = (fx_time < 16'd8) ? 8 : fx_time / 4;
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'($urandom_range(0, 2));
            1, 2:    return 16'($urandom());
            default: return 16'($urandom_range(0, span));
        endcase
    endfunction

    function automatic logic [7:0] pick_colour();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_time();
        case ($urandom_range(0, 5))
            0:       return 16'd1;
            1:       return 16'hffff;
            2:       return 16'($urandom_range(1, 200));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    initial begin
        int pick;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset settings: no effect, light toggling, trigger ignored while running
        push_req(lpfr_pkg::ITEM_TICK, 16'd0);
        push_req(lpfr_pkg::ITEM_TICK, 16'hffff);
        push_req(lpfr_pkg::ITEM_LIGHT_OFF, 16'd0);
        push_req(lpfr_pkg::ITEM_TICK, 16'd100);
        push_req(lpfr_pkg::ITEM_LIGHT_ON, 16'd0);
        push_req(lpfr_pkg::ITEM_TRIGGER, 16'd0);
        push_req(lpfr_pkg::ITEM_TICK, 16'd1);
        settle();

        // pulse with a unit step per ms: exact landings on 0.0 and 1.0, turns, saturation
        set_config(lpfr_pkg::EFFECT_PULSE, 16'd32768, 1'b1, 8'd255, 8'd0, 8'd128);
        push_req(lpfr_pkg::ITEM_TICK, 16'd32768);
        push_req(lpfr_pkg::ITEM_TICK, 16'd0);
        push_req(lpfr_pkg::ITEM_TICK, 16'd1);
        push_req(lpfr_pkg::ITEM_TICK, 16'd32768);
        push_req(lpfr_pkg::ITEM_TICK, 16'd1);
        push_req(lpfr_pkg::ITEM_TICK, 16'hffff);
        push_req(lpfr_pkg::ITEM_TICK, 16'd16384);
        settle();

        // fade, zero effect time, waiting for a trigger
        set_config(lpfr_pkg::EFFECT_FADE, 16'd0, 1'b0, 8'd200, 8'd100, 8'd7);
        push_req(lpfr_pkg::ITEM_TICK, 16'd5);
        push_req(lpfr_pkg::ITEM_TRIGGER, 16'd0);
        push_req(lpfr_pkg::ITEM_TICK, 16'd0);
        push_req(lpfr_pkg::ITEM_TICK, 16'd1);
        push_req(lpfr_pkg::ITEM_TICK, 16'd9);
        settle();

        // unused effect code holds the factor
        set_config(2'd3, 16'hffff, 1'b1, 8'd255, 8'd255, 8'd255);
        push_req(lpfr_pkg::ITEM_TICK, 16'hffff);
        push_req(lpfr_pkg::ITEM_TICK, 16'd12);
        settle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_config(lpfr_pkg::EFFECT_PULSE, 16'hffff, 1'b1, 8'd255, 8'd255, 8'd255);
                1: set_config(lpfr_pkg::EFFECT_FADE, 16'd1, 1'b0, 8'd0, 8'd0, 8'd0);
                default: set_config(2'($urandom_range(0, 3)) | 2'($urandom_range(0, 1)),
                                    pick_time(), 1'($urandom()), pick_colour(),
                                    pick_colour(), pick_colour());
            endcase
            case ($urandom_range(0, 2))
                0:       s_idle_pct = 0;
                1:       s_idle_pct = 15;
                default: s_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       m_idle_pct = 0;
                1:       m_idle_pct = 15;
                default: m_idle_pct = 40;
            endcase
            quiet = (p == 7);
            for (int k = 0; k < 175; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    push_req(lpfr_pkg::ITEM_TICK, pick_elapsed());
                else if (pick < 84)
                    push_req(lpfr_pkg::ITEM_TRIGGER, 16'($urandom()));
                else if (pick < 92)
                    push_req(lpfr_pkg::ITEM_LIGHT_ON, 16'($urandom()));
                else
                    push_req(lpfr_pkg::ITEM_LIGHT_OFF, 16'($urandom()));
            end
            // receiver backs off for a long spell while ticks keep coming
            if (p == 2) hold_req = 1'b1;
            settle();
        end

        $display("%0d requests accepted over %0d register settings, %0d colour results checked",
                 n_accepted, n_phases, n_checked);
        $display("pulse direction changes seen: %0d, long receiver hold-off done: %0d",
                 n_turns, hold_done);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
